// ===== src/lir_pkg.sv =====
// lir_pkg: shared constants, register indexes and rate clamp for the resampler
// no dependencies; imported by the top level, the serial units and the checker
package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RATE_BITS       = 17;
  localparam int PHASE_BITS      = 18;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CHAN_BITS       = 2;
  localparam int MAX_RESULTS     = 24;
  localparam int RES_CNT_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic [RATE_BITS-1:0] RATE_MIN = RATE_BITS'(8000);
  localparam logic [RATE_BITS-1:0] RATE_MAX = RATE_BITS'(96000);
  localparam logic [RATE_BITS-1:0] RATE_RST = RATE_BITS'(48000);
  localparam logic [CHAN_BITS-1:0] CHAN_RST = CHAN_BITS'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_RATE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_RATE = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS = CFG_IDX_BITS'(2);

  function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [RATE_BITS-1:0] r);
    logic [RATE_BITS-1:0] res;
    res = r;
    if (r < RATE_MIN) res = RATE_MIN;
    else if (r > RATE_MAX) res = RATE_MAX;
    return res;
  endfunction

endpackage

// ===== src/linear_interp_resampler.sv =====
// linear_interp_resampler: each result is worked out by the bit-serial multiply
// (17 steps) and then the restoring divide (SAMPLE_BITS steps); the input is
// held off until every result of the frame has been worked out.
// a result leaves once the next one of its frame is done or the frame ends.
// synchronous active-high reset: rates 48000, stereo, no frame held, output empty.
// depends on lir_pkg, lir_mac, lir_div
module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input frame channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        left_sample,
  input  logic signed [SAMPLE_BITS-1:0]        right_sample,
  input  logic                                 last_frame,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        left_out,
  output logic signed [SAMPLE_BITS-1:0]        right_out,
  output logic                                 last_of_run,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lir_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lir_pkg::RATE_BITS-1:0]        cfg_data
);
  import lir_pkg::*;

  // sequencer, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,  // waiting for a frame
    S_MAIN = 7'b0000010,  // interpolate between held frame and new frame
    S_POST = 7'b0000100,  // new frame becomes the held frame
    S_TAIL = 7'b0001000,  // repeat last frame up to the buffer's output count
    S_BUSY = 7'b0010000,  // serial multiply and divide running
    S_PUSH = 7'b0100000,  // park the result, older parked result goes out
    S_FIN  = 7'b1000000   // flush the parked result with the run-end flag
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [RATE_BITS-1:0]    in_rate;
  logic [RATE_BITS-1:0]    out_rate;
  logic [CHAN_BITS-1:0]    channel_count;

  // per-frame working state
  logic [RATE_BITS-1:0]    ir;
  logic [RATE_BITS-1:0]    orr;
  logic                    stereo;
  logic                    last_q;
  logic                    in_tail;
  logic signed [SAMPLE_BITS-1:0] cur_l;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic signed [SAMPLE_BITS-1:0] prev_l;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic                    have_prev;
  logic [PHASE_BITS-1:0]   phase;
  logic [RES_CNT_BITS-1:0] n;

  // parked result, waits until we know whether it ends the run
  logic                    pend_valid;
  logic signed [SAMPLE_BITS-1:0] pend_l;
  logic signed [SAMPLE_BITS-1:0] pend_r;

  // serial lanes
  logic                    mac_start;
  logic signed [SAMPLE_BITS-1:0] op_s1_l, op_s2_l, op_s1_r, op_s2_r;
  logic [RATE_BITS-1:0]    op_r;
  logic                    mac_done_l, mac_done_r;
  logic                    neg_l, neg_r;
  logic [SAMPLE_BITS+RATE_BITS-1:0] mag_l, mag_r;
  logic                    div_done_l, div_done_r;
  logic [SAMPLE_BITS-1:0]  quot_l, quot_r;

  // control terms
  logic                    in_accept;
  logic                    out_free;
  logic                    room;
  logic                    main_go;
  logic                    tail_go;
  logic                    push_ok;
  logic                    out_load;
  logic [PHASE_BITS:0]     tail_pos;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign room     = (n < RES_CNT_BITS'(MAX_RESULTS));
  assign main_go  = (phase < PHASE_BITS'(orr)) && room;
  assign tail_pos = {1'b0, phase} + (PHASE_BITS + 1)'(ir);
  assign tail_go  = (tail_pos <= (PHASE_BITS + 1)'(orr)) && room;
  assign push_ok  = !pend_valid || out_free;
  // a parked result goes out when a newer one displaces it or the frame ends
  assign out_load = pend_valid && out_free && ((state == S_PUSH) || (state == S_FIN));

  // tail outputs reuse the datapath with equal endpoints and zero remainder
  assign mac_start = ((state == S_MAIN) && main_go) || ((state == S_TAIL) && tail_go);
  assign op_s1_l   = (state == S_TAIL) ? cur_l : prev_l;
  assign op_s1_r   = (state == S_TAIL) ? cur_r : prev_r;
  assign op_s2_l   = cur_l;
  assign op_s2_r   = cur_r;
  assign op_r      = (state == S_TAIL) ? '0 : phase[RATE_BITS-1:0];

  lir_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_l (
    .clk(clk), .rst(rst), .start(mac_start),
    .s1(op_s1_l), .s2(op_s2_l), .r(op_r), .den(orr),
    .done(mac_done_l), .neg(neg_l), .mag(mag_l)
  );

  lir_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_r (
    .clk(clk), .rst(rst), .start(mac_start),
    .s1(op_s1_r), .s2(op_s2_r), .r(op_r), .den(orr),
    .done(mac_done_r), .neg(neg_r), .mag(mag_r)
  );

  lir_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_l (
    .clk(clk), .rst(rst), .start(mac_done_l),
    .neg(neg_l), .mag(mag_l), .den(orr),
    .done(div_done_l), .quot(quot_l)
  );

  lir_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_r (
    .clk(clk), .rst(rst), .start(mac_done_r),
    .neg(neg_r), .mag(mag_r), .den(orr),
    .done(div_done_r), .quot(quot_r)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = have_prev ? S_MAIN : S_POST;
      S_MAIN: state_next = main_go ? S_BUSY : S_POST;
      S_POST: state_next = last_q ? S_TAIL : S_FIN;
      S_TAIL: state_next = tail_go ? S_BUSY : S_FIN;
      // both lanes run in lockstep, move on once both quotients are in
      S_BUSY: if (div_done_l && div_done_r) state_next = S_PUSH;
      S_PUSH: if (push_ok) state_next = in_tail ? S_TAIL : S_MAIN;
      S_FIN:  if (!pend_valid || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_rate       <= RATE_RST;
      out_rate      <= RATE_RST;
      channel_count <= CHAN_RST;
      have_prev     <= 1'b0;
      phase         <= '0;
      n             <= '0;
      in_tail       <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IN_RATE:  in_rate       <= cfg_data;
          REG_OUT_RATE: out_rate      <= cfg_data;
          REG_CHANNELS: channel_count <= cfg_data[CHAN_BITS-1:0];
          default: ;  // writes past the register list are dropped
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            n <= '0;
            // a new buffer starts at position zero
            if (!have_prev) phase <= '0;
          end
        end
        S_MAIN: begin
          if (main_go) begin
            phase   <= PHASE_BITS'(phase + PHASE_BITS'(ir));
            n       <= n + 1'b1;
            in_tail <= 1'b0;
          end else if (phase >= PHASE_BITS'(orr)) begin
            phase <= PHASE_BITS'(phase - PHASE_BITS'(orr));
          end
        end
        S_POST: have_prev <= 1'b1;
        S_TAIL: begin
          if (tail_go) begin
            phase   <= tail_pos[PHASE_BITS-1:0];
            n       <= n + 1'b1;
            in_tail <= 1'b1;
          end else begin
            // end of buffer, back to the reset position
            have_prev <= 1'b0;
            phase     <= '0;
          end
        end
        S_BUSY: ;
        S_PUSH: if (push_ok) pend_valid <= 1'b1;
        S_FIN:  if (pend_valid && out_free) pend_valid <= 1'b0;
        default: ;
      endcase

      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ir     <= clamp_rate(in_rate);
      orr    <= clamp_rate(out_rate);
      stereo <= channel_count[1];
      last_q <= last_frame;
      cur_l  <= left_sample;
      // mono: right lane carries zero
      cur_r  <= channel_count[1] ? right_sample : '0;
    end
    if (state == S_POST) begin
      prev_l <= cur_l;
      prev_r <= cur_r;
    end else if ((state == S_TAIL) && !tail_go) begin
      prev_l <= '0;
      prev_r <= '0;
    end
    if ((state == S_PUSH) && push_ok) begin
      pend_l <= quot_l;
      pend_r <= stereo ? quot_r : '0;
    end
    if (out_load) begin
      left_out    <= pend_l;
      right_out   <= pend_r;
      last_of_run <= (state == S_FIN);
    end
  end

endmodule

// ===== src/lir_mac.sv =====
// lir_mac: bit-serial sum of two products s1*(den-r) + s2*r, msb first
// depends on lir_pkg; hands sign and magnitude to lir_div
module lir_mac #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic signed [SAMPLE_BITS-1:0]               s1,
  input  logic signed [SAMPLE_BITS-1:0]               s2,
  input  logic [lir_pkg::RATE_BITS-1:0]               r,
  input  logic [lir_pkg::RATE_BITS-1:0]               den,
  output logic                                        done,
  output logic                                        neg,
  output logic [SAMPLE_BITS+lir_pkg::RATE_BITS-1:0]   mag
);
  import lir_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + RATE_BITS + 1;
  localparam int CNT_W = $clog2(RATE_BITS);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [RATE_BITS-1:0]    wa;
  logic [RATE_BITS-1:0]    wr;
  logic signed [SAMPLE_BITS-1:0] a1;
  logic signed [SAMPLE_BITS-1:0] a2;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] add1;
  logic signed [ACC_W-1:0] add2;
  logic [ACC_W-1:0]        acc_abs;

  assign add1 = wa[RATE_BITS-1] ? ACC_W'(a1) : '0;
  assign add2 = wr[RATE_BITS-1] ? ACC_W'(a2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RATE_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        else cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      wa  <= den - r;
      wr  <= r;
      a1  <= s1;
      a2  <= s2;
      acc <= '0;
    end else if (busy) begin
      acc <= (acc <<< 1) + add1 + add2;
      wa  <= {wa[RATE_BITS-2:0], 1'b0};
      wr  <= {wr[RATE_BITS-2:0], 1'b0};
    end
  end

  assign neg     = acc[ACC_W-1];
  assign acc_abs = neg ? (~acc + 1'b1) : acc;
  assign mag     = acc_abs[SAMPLE_BITS+RATE_BITS-1:0];

endmodule

// ===== src/lir_div.sv =====
// lir_div: restoring divider, one quotient bit per cycle, sign applied at the end
// depends on lir_pkg; fed by lir_mac
module lir_div #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic                                        neg,
  input  logic [SAMPLE_BITS+lir_pkg::RATE_BITS-1:0]   mag,
  input  logic [lir_pkg::RATE_BITS-1:0]               den,
  output logic                                        done,
  output logic [SAMPLE_BITS-1:0]                      quot
);
  import lir_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [RATE_BITS-1:0]   rem;
  logic [SAMPLE_BITS-1:0] low;
  logic [SAMPLE_BITS-1:0] q;
  logic                   neg_q;
  logic [RATE_BITS:0]     trial;
  logic                   fits;

  assign trial = {rem, low[SAMPLE_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SAMPLE_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        else cnt <= cnt - 1'b1;
      end
    end
  end

  // upper part of the dividend is already below den, so SAMPLE_BITS steps suffice
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= mag[SAMPLE_BITS+RATE_BITS-1:SAMPLE_BITS];
      low   <= mag[SAMPLE_BITS-1:0];
      q     <= '0;
      neg_q <= neg;
    end else if (busy) begin
      rem <= fits ? RATE_BITS'(trial - {1'b0, den}) : trial[RATE_BITS-1:0];
      low <= {low[SAMPLE_BITS-2:0], 1'b0};
      q   <= {q[SAMPLE_BITS-2:0], fits};
    end
  end

  assign quot = neg_q ? (~q + 1'b1) : q;

endmodule

// ===== src/lir_checker.sv =====
// lir_checker: port-level checks of the resampler, bound to the top level
// depends on lir_pkg and linear_interp_resampler
module lir_checker #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [SAMPLE_BITS-1:0]        left_out,
  input logic signed [SAMPLE_BITS-1:0]        right_out,
  input logic                                 last_of_run,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [lir_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input logic [lir_pkg::RATE_BITS-1:0]        cfg_data
);
  import lir_pkg::*;

  // mono mode as seen from the configuration writes
  logic mono;
  always_ff @(posedge clk) begin
    if (rst) mono <= 1'b0;
    else if (cfg_valid && cfg_ready && (cfg_index == REG_CHANNELS)) mono <= !cfg_data[1];
  end

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat present right after reset");

  // one frame at a time: an accepted beat closes the input
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a frame");

  // mono results carry zero on the right lane
  a_mono_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mono) |-> (right_out == '0))
    else $error("nonzero right result in mono mode");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(left_out) && $stable(right_out) && $stable(last_of_run)))
    else $error("stalled result beat changed");

endmodule

bind linear_interp_resampler lir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lir_checker (.*);
